>>> hw/rtl/fhp_pkg.sv
`timescale 1ns / 1ps

package fhp_pkg;

    // hash constants
    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [15:0] COUNT_MAX = 16'hffff;

    // configuration register indexes and reset values
    localparam int          CFG_IDX_W           = 2;
    localparam logic [1:0]  REG_PARTITION_COUNT = 2'd0;
    localparam logic [1:0]  REG_PREFIX_LIMIT    = 2'd1;
    localparam logic [15:0] PART_COUNT_RESET    = 16'd1;
    localparam logic [15:0] PREFIX_LIMIT_RESET  = 16'hffff;

    // default depth of the queue between hashing and reduction
    localparam int          QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_end;
    } t_in_word;

    typedef struct packed {
        logic [15:0] partition_index;
        logic [31:0] key_hash;
    } t_out_word;

    // handshake between the queue and one of its neighbors
    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_hs;

endpackage

>>> hw/rtl/fhp_front.sv
`timescale 1ns / 1ps

module fhp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fhp_pkg::t_in_word i_in_word,
    input  logic [15:0]       i_prefix_limit,
    input  logic              i_push_ready,
    output logic              o_push_valid,
    output logic [31:0]       o_push_hash
);
    import fhp_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [15:0] r_seen;
    logic [15:0] n_seen;
    logic [31:0] w_mult;
    logic [31:0] w_step;
    logic        w_accept;

    // one fnv-1 round on the current byte
    assign w_mult   = r_hash * FNV_PRIME;
    assign w_step   = (r_seen < i_prefix_limit) ? (w_mult ^ {24'd0, i_in_word.key_byte})
                                                : r_hash;
    assign w_accept = i_in_valid && o_in_ready;

    // bytes stall only while the queue is full
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = w_accept && i_in_word.key_end;
    assign o_push_hash  = w_step;

    // next hash and byte count
    always_comb begin
        n_hash = r_hash;
        n_seen = r_seen;
        if (w_accept) begin
            if (i_in_word.key_end) begin
                n_hash = FNV_BASIS;
                n_seen = 16'd0;
            end else begin
                n_hash = w_step;
                n_seen = (r_seen != COUNT_MAX) ? (r_seen + 16'd1) : r_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_seen <= 16'd0;
        end else begin
            r_hash <= n_hash;
            r_seen <= n_seen;
        end
    end

endmodule

>>> hw/rtl/fhp_queue.sv
`timescale 1ns / 1ps

module fhp_queue #(
    parameter int DEPTH = fhp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  logic [31:0]   i_push_hash,
    output fhp_pkg::t_q_hs o_pop_hs,
    input  logic          i_pop_ready,
    output logic [31:0]   o_pop_hash
);
    import fhp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [31:0]   r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready   = (r_count != FULL_CNT);
    assign o_pop_hs.valid = (r_count != '0);
    assign o_pop_hs.ready = i_pop_ready;
    assign o_pop_hash     = r_mem[r_rd_ptr];
    assign w_push         = i_push_valid && o_push_ready;
    assign w_pop          = o_pop_hs.valid && i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_hash;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : (r_wr_ptr + AW'(1));
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : (r_rd_ptr + AW'(1));
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count exceeds depth");
    a_push_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_valid |-> o_push_ready)
        else $error("hash pushed into full queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

>>> hw/rtl/fhp_back.sv
`timescale 1ns / 1ps

module fhp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fhp_pkg::t_q_hs     i_pop_hs,
    output logic               o_pop_ready,
    input  logic [31:0]        i_pop_hash,
    input  logic [15:0]        i_part_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fhp_pkg::t_out_word o_out_word
);
    import fhp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [4:0]  r_cnt;
    logic [31:0] r_hash;
    logic [31:0] r_dvd;
    logic [16:0] r_rem;
    logic        r_out_valid;
    t_out_word   r_out_word;
    logic [16:0] w_shift;
    logic [16:0] w_diff;
    logic        w_out_free;
    logic        w_load;

    assign o_pop_ready = (r_state == ST_IDLE);
    assign w_load      = i_pop_hs.valid && o_pop_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // one restoring division step
    assign w_shift = {r_rem[15:0], r_dvd[31]};
    assign w_diff  = w_shift - {1'b0, i_part_count};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider datapath and output word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_hash <= i_pop_hash;
            r_dvd  <= i_pop_hash;
            r_rem  <= 17'd0;
        end else if (r_state == ST_DIV) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= w_diff[16] ? w_shift : w_diff;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_word.key_hash        <= r_hash;
            r_out_word.partition_index <= (i_part_count == 16'd0) ? 16'd0 : r_rem[15:0];
        end
    end

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_part_count != 16'd0) |-> (r_rem[15:0] < i_part_count))
        else $error("remainder not reduced below partition count");
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == 5'd0))
        else $error("step counter not cleared between keys");
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_word))
        else $error("result word changed while stalled");
`endif

endmodule

>>> hw/rtl/fnv_hash_key_partitioner.sv
`timescale 1ns / 1ps

// fnv-1 32-bit key hasher and partitioner
// input channel: one key byte per word, key_end marks the last byte of a key.
// output channel: one word per key with the hash and hash mod partition_count.
// config channel: index 0 sets partition_count, index 1 sets prefix_byte_limit;
// other indexes are dropped. write only while no key is in flight.
// throughput: the hash front takes one byte per cycle as long as the queue
// of finished hashes has room. each finished key then passes through the
// back end: a load, 32 bit-serial remainder steps and a register of the
// result; the back end takes no new key until it is done. short keys can
// throttle the front through the queue. the hash of a key's last byte goes
// through the queue, the back-end divider and the output register.
// reset: hash returns to the offset basis, byte count and queue clear,
// partition_count goes to 1 and prefix_byte_limit to 65535.
// when the receiver stalls the result word holds; the back end finishes its
// current division and waits, the queue fills, then bytes stall.
module fnv_hash_key_partitioner #(
    parameter int QUEUE_DEPTH = fhp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fhp_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fhp_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fhp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import fhp_pkg::*;

    logic [15:0] r_part_count;
    logic [15:0] r_prefix_limit;
    logic        w_push_valid;
    logic        w_push_ready;
    logic [31:0] w_push_hash;
    t_q_hs       w_pop_hs;
    logic        w_pop_ready;
    logic [31:0] w_pop_hash;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count   <= PART_COUNT_RESET;
            r_prefix_limit <= PREFIX_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PARTITION_COUNT: r_part_count   <= i_cfg_data;
                REG_PREFIX_LIMIT:    r_prefix_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // byte hashing
    fhp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_word      (i_in_word),
        .i_prefix_limit (r_prefix_limit),
        .i_push_ready   (w_push_ready),
        .o_push_valid   (w_push_valid),
        .o_push_hash    (w_push_hash)
    );

    // finished hashes
    fhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_hash  (w_push_hash),
        .o_pop_hs     (w_pop_hs),
        .i_pop_ready  (w_pop_ready),
        .o_pop_hash   (w_pop_hash)
    );

    // partition reduction and output register
    fhp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_hs     (w_pop_hs),
        .o_pop_ready  (w_pop_ready),
        .i_pop_hash   (w_pop_hash),
        .i_part_count (r_part_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule
